### design/afd_pkg.sv
// ----------------------------------------------------------------------------
// afd_pkg - shared definitions for the ADPCM frame decoder
// Frame layout constants, register indexes and the coefficient table.
// ----------------------------------------------------------------------------
package afd_pkg;

	// Frame layout
	localparam int unsigned FRAME_BYTES  = 140;
	localparam int unsigned HEADER_BYTES = 12;
	localparam int unsigned MAX_CHANNELS = 8;

	// Field widths
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned SAMPLE_W = 16;
	localparam int unsigned CHAN_W   = 3;
	localparam int unsigned POS_W    = 32;
	localparam int unsigned COUNT_W  = 4;
	localparam int unsigned FRAME_W  = 24;
	localparam int unsigned COEF_W   = 7;
	localparam int unsigned ACC_W    = 27;

	// Configuration register indexes
	typedef enum logic [0:0] {
		CFG_CHANNEL_COUNT = 1'b0,
		CFG_TOTAL_SAMPLES = 1'b1
	} cfg_index_t;

	typedef logic [COEF_W-1:0] coef_t;

	typedef struct packed {
		coef_t c0;
		coef_t c1;
	} coef_pair_t;

	// Coefficient pair for a selector nibble; the selector is taken mod 7 and
	// pairs five and six are zero.
	function automatic coef_pair_t coef_lookup(input logic [3:0] sel);
		coef_pair_t p;
		case (sel)
			4'd1, 4'd8, 4'd15: p = '{c0: 7'd60,  c1: 7'd0};
			4'd2, 4'd9:        p = '{c0: 7'd122, c1: 7'd60};
			4'd3, 4'd10:       p = '{c0: 7'd115, c1: 7'd52};
			4'd4, 4'd11:       p = '{c0: 7'd98,  c1: 7'd55};
			default:           p = '{c0: 7'd0,   c1: 7'd0};
		endcase
		return p;
	endfunction

endpackage

### design/afd_stream_if.sv
// ----------------------------------------------------------------------------
// afd_stream_if - valid/ready channels of the ADPCM frame decoder
// Byte channel towards the decoder and sample channel from it.
// ----------------------------------------------------------------------------
interface afd_byte_if;
	logic                         valid;
	logic                         ready;
	logic [afd_pkg::BYTE_W-1:0]   stream_byte;

	modport source (output valid, output stream_byte, input ready);
	modport sink   (input valid, input stream_byte, output ready);
endinterface

interface afd_sample_if;
	logic                                valid;
	logic                                ready;
	logic signed [afd_pkg::SAMPLE_W-1:0] pcm_sample;
	logic [afd_pkg::CHAN_W-1:0]          channel_index;
	logic [afd_pkg::POS_W-1:0]           sample_position;
	logic                                last_in_item;

	modport source (output valid, output pcm_sample, output channel_index,
		output sample_position, output last_in_item, input ready);
	modport sink   (input valid, input pcm_sample, input channel_index,
		input sample_position, input last_in_item, output ready);
endinterface

### design/adpcm_frame_decoder_core.sv
// ----------------------------------------------------------------------------
// adpcm_frame_decoder_core - streaming 4-bit ADPCM frame decoder
// Decodes interleaved 140-byte frames into saturated 16-bit samples.
// ----------------------------------------------------------------------------
// Usage:
//   byte_in carries the compressed stream, one byte per request, in file
//   order. sample_out carries decoded samples with their channel, position
//   within the channel and a flag on the last sample of each data byte.
//   cfg_write/cfg_index/cfg_data set the channel count and the number of
//   samples per channel to emit; write them only while the block is idle.
// Timing:
//   A header byte is taken and gives no sample. After a data byte is taken,
//   byte_in stays not ready until both of its nibbles are done: each nibble uses the one
//   shared 16x8 multiplier twice (h1*c0, then h2*c1) and a third step to
//   shift, saturate and load the output register. A new data byte is therefore
//   taken only after the last one is fully decoded; each sample appears in
//   the output register the cycle after its saturate step.
// Stall:
//   A sample waits in the output register until taken; a following sample
//   holds the sequencer in its saturate step until the register frees.
// Reset:
//   arst_n clears the frame position, header state, history, channel and
//   frame number; channel count returns to 1 and the sample total to 0.
// ----------------------------------------------------------------------------
module adpcm_frame_decoder_core (
	input  logic                           clk,
	input  logic                           arst_n,
	afd_byte_if.sink                       byte_in,
	afd_sample_if.source                   sample_out,
	input  logic                           cfg_write,
	input  afd_pkg::cfg_index_t            cfg_index,
	input  logic [afd_pkg::POS_W-1:0]      cfg_data
);

	// Sequencer states
	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_MUL1 = 4'b0010,
		S_MUL2 = 4'b0100,
		S_SAT  = 4'b1000
	} state_t;

	state_t state_q;

	// Configuration and frame state
	logic [afd_pkg::COUNT_W-1:0]  channel_count_q;
	logic [afd_pkg::POS_W-1:0]    total_samples_q;
	logic [7:0]                   byte_in_frame_q;
	logic [31:0]                  selector_q;
	logic [31:0]                  shift_q;
	logic [15:0]                  history_one_q;
	logic [15:0]                  history_two_q;
	logic [afd_pkg::CHAN_W-1:0]   current_channel_q;
	logic [afd_pkg::FRAME_W-1:0]  frame_number_q;

	// Working registers of the byte being decoded
	logic [7:0]                   byte_q;
	logic                         nib_sel_q;
	afd_pkg::coef_t               coef0_q;
	afd_pkg::coef_t               coef1_q;
	logic [3:0]                   shf_q;
	logic [afd_pkg::POS_W-1:0]    spos_q;
	logic [afd_pkg::CHAN_W-1:0]   chan_q;
	logic signed [afd_pkg::ACC_W-1:0] acc_q;

	// Output register
	logic                         out_valid_q;
	logic signed [15:0]           out_sample_q;
	logic [afd_pkg::CHAN_W-1:0]   out_chan_q;
	logic [afd_pkg::POS_W-1:0]    out_pos_q;
	logic                         out_last_q;

	logic                         in_accept;
	logic                         is_header;
	logic [6:0]                   data_idx;
	logic [2:0]                   nib_set;
	afd_pkg::coef_pair_t          pair;
	logic                         frame_end;
	logic [afd_pkg::COUNT_W-1:0]  eff_count;
	logic [afd_pkg::COUNT_W-1:0]  next_chan;

	logic [3:0]                   nibble;
	logic signed [15:0]           mul_h;
	logic signed [7:0]            mul_c;
	logic signed [23:0]           product;
	logic signed [afd_pkg::ACC_W-1:0] base;
	logic signed [20:0]           shifted;
	logic [15:0]                  sat_sample;
	logic [afd_pkg::POS_W-1:0]    spos_cur;
	logic                         keep;
	logic                         keep_next;
	logic                         can_load;
	logic                         sat_stall;

	// Input decode
	assign in_accept = byte_in.valid && byte_in.ready;
	assign byte_in.ready = (state_q == S_IDLE);
	assign is_header = (byte_in_frame_q < 8'(afd_pkg::HEADER_BYTES));
	assign data_idx  = 7'(byte_in_frame_q - 8'(afd_pkg::HEADER_BYTES));
	assign nib_set   = data_idx[6:4];
	assign pair      = afd_pkg::coef_lookup(selector_q[nib_set*4 +: 4]);
	assign frame_end = (byte_in_frame_q == 8'(afd_pkg::FRAME_BYTES - 1));

	// Effective channel count, clamped to 1..MAX_CHANNELS
	always_comb begin
		if (channel_count_q == '0) begin
			eff_count = afd_pkg::COUNT_W'(1);
		end else if (channel_count_q > afd_pkg::COUNT_W'(afd_pkg::MAX_CHANNELS)) begin
			eff_count = afd_pkg::COUNT_W'(afd_pkg::MAX_CHANNELS);
		end else begin
			eff_count = channel_count_q;
		end
	end
	assign next_chan = {1'b0, current_channel_q} + afd_pkg::COUNT_W'(1);

	// Shared multiplier: h1*c0 in the first step, h2*c1 in the second
	assign nibble  = nib_sel_q ? byte_q[7:4] : byte_q[3:0];
	assign mul_h   = (state_q == S_MUL1) ? history_one_q : history_two_q;
	assign mul_c   = (state_q == S_MUL1) ? $signed({1'b0, coef0_q}) : $signed({1'b0, coef1_q});
	assign product = mul_h * mul_c;
	assign base    = afd_pkg::ACC_W'($signed(nibble)) <<< (5'd6 + 5'(shf_q));

	// Floor shift and saturation
	assign shifted = 21'(acc_q >>> 6);
	always_comb begin
		if (shifted > 21'sd32767) begin
			sat_sample = 16'h7FFF;
		end else if (shifted < -21'sd32768) begin
			sat_sample = 16'h8000;
		end else begin
			sat_sample = shifted[15:0];
		end
	end

	// Position filter and output register availability
	assign spos_cur  = {spos_q[afd_pkg::POS_W-1:1], nib_sel_q};
	assign keep      = (spos_cur < total_samples_q);
	assign keep_next = ({spos_q[afd_pkg::POS_W-1:1], 1'b1} < total_samples_q);
	assign can_load  = !out_valid_q || sample_out.ready;
	assign sat_stall = keep && !can_load;

	// Sequencer and model state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= S_IDLE;
			channel_count_q   <= afd_pkg::COUNT_W'(1);
			total_samples_q   <= '0;
			byte_in_frame_q   <= '0;
			selector_q        <= '0;
			shift_q           <= '0;
			history_one_q     <= '0;
			history_two_q     <= '0;
			current_channel_q <= '0;
			frame_number_q    <= '0;
			nib_sel_q         <= 1'b0;
			out_valid_q       <= 1'b0;
		end else begin
			// configuration writes
			if (cfg_write) begin
				case (cfg_index)
					afd_pkg::CFG_CHANNEL_COUNT: channel_count_q <= cfg_data[afd_pkg::COUNT_W-1:0];
					afd_pkg::CFG_TOTAL_SAMPLES: total_samples_q <= cfg_data;
					default: ;
				endcase
			end

			// output register drains
			if (out_valid_q && sample_out.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (in_accept) begin
						case (byte_in_frame_q) inside
							[8'd0:8'd3]: selector_q[byte_in_frame_q[1:0]*8 +: 8] <= byte_in.stream_byte;
							[8'd4:8'd7]: shift_q[byte_in_frame_q[1:0]*8 +: 8] <= byte_in.stream_byte;
							8'd8:  history_one_q[7:0]  <= byte_in.stream_byte;
							8'd9:  history_one_q[15:8] <= byte_in.stream_byte;
							8'd10: history_two_q[7:0]  <= byte_in.stream_byte;
							8'd11: history_two_q[15:8] <= byte_in.stream_byte;
							default: begin
								nib_sel_q <= 1'b0;
								state_q   <= S_MUL1;
							end
						endcase
						// frame position advance
						if (frame_end) begin
							byte_in_frame_q <= '0;
							if (next_chan >= eff_count) begin
								current_channel_q <= '0;
								frame_number_q    <= frame_number_q + afd_pkg::FRAME_W'(1);
							end else begin
								current_channel_q <= next_chan[afd_pkg::CHAN_W-1:0];
							end
						end else begin
							byte_in_frame_q <= byte_in_frame_q + 8'd1;
						end
					end
				end
				S_MUL1: state_q <= S_MUL2;
				S_MUL2: state_q <= S_SAT;
				S_SAT: begin
					if (!sat_stall) begin
						history_two_q <= history_one_q;
						history_one_q <= sat_sample;
						if (keep) begin
							out_valid_q <= 1'b1;
						end
						if (nib_sel_q) begin
							state_q <= S_IDLE;
						end else begin
							nib_sel_q <= 1'b1;
							state_q   <= S_MUL1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Working and output payload registers
	always_ff @(posedge clk) begin
		if (in_accept && !is_header) begin
			byte_q  <= byte_in.stream_byte;
			coef0_q <= pair.c0;
			coef1_q <= pair.c1;
			shf_q   <= shift_q[nib_set*4 +: 4];
			spos_q  <= {frame_number_q, data_idx, 1'b0};
			chan_q  <= current_channel_q;
		end
		if (state_q == S_MUL1) begin
			acc_q <= base + afd_pkg::ACC_W'(product);
		end else if (state_q == S_MUL2) begin
			acc_q <= acc_q - afd_pkg::ACC_W'(product);
		end
		if (state_q == S_SAT && keep && can_load) begin
			out_sample_q <= sat_sample;
			out_chan_q   <= chan_q;
			out_pos_q    <= spos_cur;
			out_last_q   <= nib_sel_q || !keep_next;
		end
	end

	assign sample_out.valid           = out_valid_q;
	assign sample_out.pcm_sample      = out_sample_q;
	assign sample_out.channel_index   = out_chan_q;
	assign sample_out.sample_position = out_pos_q;
	assign sample_out.last_in_item    = out_last_q;

	// Checks
	a_frame_pos: assert property (@(posedge clk) disable iff (!arst_n)
		byte_in_frame_q < 8'(afd_pkg::FRAME_BYTES))
		else $error("frame position out of range");

	a_data_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept && !is_header |=> state_q == S_MUL1 && !nib_sel_q)
		else $error("data byte did not start decoding");

	a_sat_holds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SAT && sat_stall |=> state_q == S_SAT && $stable(history_one_q))
		else $error("sample lost while output register full");

	a_byte_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SAT && !sat_stall && nib_sel_q |=> state_q == S_IDLE)
		else $error("sequencer did not return after second nibble");

	a_load_flag: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SAT && keep && !sat_stall |=> out_valid_q)
		else $error("kept sample not presented");

endmodule
